FILE: hdl/asd_pkg.sv
package asd_pkg;

    localparam int FILTER_DEPTH = 4;
    localparam int HIST_ROWS    = FILTER_DEPTH - 1;
    localparam int AXES         = 3;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 24;
    localparam int INTERVAL_W = 10;
    localparam int PERIOD_W   = 8;
    localparam int NOISE_W    = 16;
    localparam int DIVISOR_W  = 8;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int FILL_W  = $clog2(FILTER_DEPTH + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(FILTER_DEPTH);
    localparam int RECIP_K = SUM_W + 2;
    localparam int RECIP_W = RECIP_K + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam int DIV_CNT_W = $clog2(NOISE_W);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [STEP_W-1:0]          step_t;
    typedef logic [INTERVAL_W-1:0]      interval_t;
    typedef logic [PERIOD_W-1:0]        period_t;
    typedef logic [NOISE_W-1:0]         noise_t;
    typedef logic [DIVISOR_W-1:0]       divisor_t;
    typedef logic [AXIS_W-1:0]          axis_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    localparam axis_t AXIS_X    = 2'd0;
    localparam axis_t AXIS_Y    = 2'd1;
    localparam axis_t AXIS_Z    = 2'd2;
    localparam axis_t AXIS_NONE = 2'd3;

    localparam cfg_idx_t REG_MIN_INTERVAL  = 2'd0;
    localparam cfg_idx_t REG_MAX_INTERVAL  = 2'd1;
    localparam cfg_idx_t REG_UPDATE_PERIOD = 2'd2;
    localparam cfg_idx_t REG_NOISE_DIVISOR = 2'd3;

    localparam interval_t MIN_INTERVAL_RST  = 10'd10;
    localparam interval_t MAX_INTERVAL_RST  = 10'd100;
    localparam period_t   UPDATE_PERIOD_RST = 8'd10;
    localparam divisor_t  NOISE_DIVISOR_RST = 8'd10;

    // reciprocals ceil(2^K / n) for n from one to eight; fill counts reach only FILTER_DEPTH
    localparam longint RECIP_ONE = longint'(1) << RECIP_K;
    localparam logic [RECIP_W-1:0] RECIP_N1 = RECIP_W'(RECIP_ONE);
    localparam logic [RECIP_W-1:0] RECIP_N2 = RECIP_W'((RECIP_ONE + 1) / 2);
    localparam logic [RECIP_W-1:0] RECIP_N3 = RECIP_W'((RECIP_ONE + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_N4 = RECIP_W'((RECIP_ONE + 3) / 4);
    localparam logic [RECIP_W-1:0] RECIP_N5 = RECIP_W'((RECIP_ONE + 4) / 5);
    localparam logic [RECIP_W-1:0] RECIP_N6 = RECIP_W'((RECIP_ONE + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_N7 = RECIP_W'((RECIP_ONE + 6) / 7);
    localparam logic [RECIP_W-1:0] RECIP_N8 = RECIP_W'((RECIP_ONE + 7) / 8);

    function automatic logic [RECIP_W-1:0] recip_of(input logic [FILL_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (4'(n))
            4'd1:    r = RECIP_N1;
            4'd2:    r = RECIP_N2;
            4'd3:    r = RECIP_N3;
            4'd4:    r = RECIP_N4;
            4'd5:    r = RECIP_N5;
            4'd6:    r = RECIP_N6;
            4'd7:    r = RECIP_N7;
            4'd8:    r = RECIP_N8;
            default: r = RECIP_N1;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic gate;
        logic diff;
        logic pick;
        logic avg_sum;
        logic avg_mul;
        logic avg_wb;
        logic upd;
        logic div_start;
        logic load_out;
    } asd_cmd_t;

    typedef struct packed {
        logic refresh;
        logic div_done;
    } asd_status_t;

endpackage

FILE: hdl/asd_if.sv
interface asd_sample_if
    import asd_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface asd_result_if
    import asd_pkg::*;
();
    logic  valid;
    logic  ready;
    step_t step_total;
    logic  step_seen;
    axis_t active_axis;

    modport source (output valid, output step_total, output step_seen,
                    output active_axis, input ready);
    modport sink (input valid, input step_total, input step_seen,
                  input active_axis, output ready);
endinterface

interface asd_cfg_if
    import asd_pkg::*;
();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/accelerometer_step_detector_core.sv
// channel   dir   word
// sample    in    accel_x, accel_y, accel_z
// result    out   step_total, step_seen, active_axis
// cfg       in    index, data (always ready)
//
// per sample word: gate, difference, axis pick, then a
// three-stage sum / reciprocal multiply / write-back average and an update step
// a sample that hits the update period also waits for the
// one-bit-per-cycle noise divider
// the next sample is taken while a result word still waits on the result channel
// rst_n clears all detector state and loads the register defaults
module accelerometer_step_detector_core
    import asd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    asd_sample_if.sink   sample,
    asd_result_if.source result,
    asd_cfg_if.sink      cfg
);

    asd_cmd_t    cmd;
    asd_status_t status;

    assign cfg.ready = 1'b1;

    asd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    asd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .accel_x     (sample.accel_x),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .step_total  (result.step_total),
        .step_seen   (result.step_seen),
        .active_axis (result.active_axis)
    );

endmodule

FILE: hdl/asd_div.sv
module asd_div
    import asd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  noise_t   dividend,
    input  divisor_t divisor,
    output noise_t   quotient,
    output logic     done
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(NOISE_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    divisor_t             rem_reg;
    divisor_t             rem_next;
    noise_t               quo_reg;
    noise_t               quo_next;
    divisor_t             dvs_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NOISE_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[NOISE_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: hdl/asd_ctrl.sv
module asd_ctrl
    import asd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  asd_status_t status,
    output asd_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIFF = 4'd1;
    localparam logic [3:0] ST_PICK = 4'd2;
    localparam logic [3:0] ST_SUM  = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_WB   = 4'd5;
    localparam logic [3:0] ST_UPD  = 4'd6;
    localparam logic [3:0] ST_DIVS = 4'd7;
    localparam logic [3:0] ST_DIVW = 4'd8;
    localparam logic [3:0] ST_EMIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.gate   = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.avg_sum = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.avg_mul = 1'b1;
                state_next  = ST_WB;
            end
            ST_WB:
            begin
                cmd.avg_wb = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = status.refresh ? ST_DIVS : ST_EMIT;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/asd_datapath.sv
module asd_datapath
    import asd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  asd_cmd_t    cmd,
    output asd_status_t status,
    input  sample_t     accel_x,
    input  sample_t     accel_y,
    input  sample_t     accel_z,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  cfg_data_t   cfg_data,
    output step_t       step_total,
    output logic        step_seen,
    output axis_t       active_axis
);

    function automatic noise_t absdiff(input sample_t a, input sample_t b);
        logic signed [SAMPLE_W:0] dif;
        logic [SAMPLE_W:0]        mag;
        dif = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        mag = dif[SAMPLE_W] ? -dif : dif;
        return mag[NOISE_W-1:0];
    endfunction

    // configuration
    interval_t min_int_reg;
    interval_t max_int_reg;
    period_t   period_reg;
    divisor_t  ndiv_reg;

    // detector state
    sample_t     fv_reg   [AXES];
    sample_t     hist_reg [HIST_ROWS][AXES];
    logic [FILL_W-1:0] fill_reg;
    sample_t     max_reg  [AXES];
    sample_t     min_reg  [AXES];
    sample_t     thr_reg  [AXES];
    noise_t      noise_reg;
    period_t     count_reg;
    interval_t   interval_reg;
    step_t       step_reg;

    // per-sample working values
    logic        act_reg   [AXES];
    noise_t      d_reg     [AXES];
    logic        cross_reg [AXES];
    logic        win_reg;
    logic        seen_reg;
    axis_t       axis_reg;
    logic [SUM_W-1:0]  mag_reg  [AXES];
    logic              neg_reg  [AXES];
    logic [PROD_W-1:0] prod_reg [AXES];
    noise_t      sw_reg    [AXES];

    // result word
    step_t       out_total_reg;
    logic        out_seen_reg;
    axis_t       out_axis_reg;

    sample_t     in_s      [AXES];
    sample_t     gate_val  [AXES];
    logic        gate_hit  [AXES];
    logic signed [SUM_W-1:0] sum_val [AXES];
    logic [SUM_W-1:0]  mag_val [AXES];
    logic [RECIP_W-1:0] recip;
    logic [NOISE_W-1:0] quo_val [AXES];
    sample_t     wb_val    [AXES];
    sample_t     thr_val   [AXES];
    noise_t      sw_val    [AXES];
    axis_t       axis_sel;
    logic        cross_hit;
    noise_t      wide01;
    noise_t      widest;
    divisor_t    div_eff;
    noise_t      div_quo;
    logic        div_done;
    logic signed [SAMPLE_W:0] pair_sum [AXES];
    logic signed [SAMPLE_W:0] pair_adj [AXES];

    assign in_s[0] = accel_x;
    assign in_s[1] = accel_y;
    assign in_s[2] = accel_z;

    assign recip = recip_of(fill_reg);

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            // noise gate
            gate_hit[i] = (absdiff(fv_reg[i], in_s[i]) > noise_reg);
            gate_val[i] = gate_hit[i] ? in_s[i] : fv_reg[i];

            // average of the held value and the filled history rows
            sum_val[i] = {{(SUM_W-SAMPLE_W){fv_reg[i][SAMPLE_W-1]}}, fv_reg[i]};
            for (int j = 0; j < HIST_ROWS; j++)
            begin
                if (FILL_W'(j + 1) < fill_reg)
                begin
                    sum_val[i] = sum_val[i]
                        + {{(SUM_W-SAMPLE_W){hist_reg[j][i][SAMPLE_W-1]}}, hist_reg[j][i]};
                end
            end
            mag_val[i] = sum_val[i][SUM_W-1] ? -sum_val[i] : sum_val[i];
            quo_val[i] = prod_reg[i][RECIP_K +: NOISE_W];
            wb_val[i]  = neg_reg[i] ? sample_t'(-quo_val[i]) : sample_t'(quo_val[i]);

            // midpoint, truncated toward zero
            pair_sum[i] = {max_reg[i][SAMPLE_W-1], max_reg[i]}
                        + {min_reg[i][SAMPLE_W-1], min_reg[i]};
            pair_adj[i] = pair_sum[i] + (SAMPLE_W+1)'(pair_sum[i][SAMPLE_W]);
            thr_val[i]  = pair_adj[i][SAMPLE_W:1];
            sw_val[i]   = absdiff(max_reg[i], min_reg[i]);
        end
    end

    // most active axis, ties to the lower axis
    always_comb
    begin
        if (act_reg[0] && d_reg[0] >= d_reg[1] && d_reg[0] >= d_reg[2])
        begin
            axis_sel = AXIS_X;
        end
        else if (act_reg[1] && d_reg[1] >= d_reg[0] && d_reg[1] >= d_reg[2])
        begin
            axis_sel = AXIS_Y;
        end
        else if (act_reg[2] && d_reg[2] >= d_reg[1] && d_reg[2] >= d_reg[0])
        begin
            axis_sel = AXIS_Z;
        end
        else
        begin
            axis_sel = AXIS_NONE;
        end
        case (axis_sel)
            AXIS_X:  cross_hit = cross_reg[0];
            AXIS_Y:  cross_hit = cross_reg[1];
            AXIS_Z:  cross_hit = cross_reg[2];
            default: cross_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        wide01  = (sw_reg[0] > sw_reg[1]) ? sw_reg[0] : sw_reg[1];
        widest  = (wide01 > sw_reg[2]) ? wide01 : sw_reg[2];
        div_eff = (ndiv_reg == '0) ? DIVISOR_W'(1) : ndiv_reg;
    end

    asd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (widest),
        .divisor  (div_eff),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign status.refresh  = (count_reg == period_reg);
    assign status.div_done = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_int_reg <= MIN_INTERVAL_RST;
            max_int_reg <= MAX_INTERVAL_RST;
            period_reg  <= UPDATE_PERIOD_RST;
            ndiv_reg    <= NOISE_DIVISOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_INTERVAL:  min_int_reg <= cfg_data[INTERVAL_W-1:0];
                REG_MAX_INTERVAL:  max_int_reg <= cfg_data[INTERVAL_W-1:0];
                REG_UPDATE_PERIOD: period_reg  <= cfg_data[PERIOD_W-1:0];
                REG_NOISE_DIVISOR: ndiv_reg    <= cfg_data[DIVISOR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                fv_reg[i]  <= '0;
                max_reg[i] <= '0;
                min_reg[i] <= '0;
                thr_reg[i] <= '0;
                for (int j = 0; j < HIST_ROWS; j++)
                begin
                    hist_reg[j][i] <= '0;
                end
            end
            fill_reg     <= FILL_W'(1);
            noise_reg    <= '0;
            count_reg    <= '0;
            interval_reg <= '0;
            step_reg     <= '0;
        end
        else
        begin
            if (cmd.gate)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    fv_reg[i] <= gate_val[i];
                end
            end
            if (cmd.diff && fill_reg < FILL_W'(FILTER_DEPTH))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.pick)
            begin
                count_reg <= count_reg + 1'b1;
                if (cross_hit)
                begin
                    interval_reg <= INTERVAL_W'(1);
                    if (win_reg)
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                else
                begin
                    interval_reg <= interval_reg + 1'b1;
                end
            end
            if (cmd.avg_wb)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    fv_reg[i] <= wb_val[i];
                    if (wb_val[i] > max_reg[i])
                    begin
                        max_reg[i] <= wb_val[i];
                    end
                    if (wb_val[i] < min_reg[i])
                    begin
                        min_reg[i] <= wb_val[i];
                    end
                end
            end
            if (cmd.upd)
            begin
                if (status.refresh)
                begin
                    count_reg <= '0;
                    for (int i = 0; i < AXES; i++)
                    begin
                        thr_reg[i] <= thr_val[i];
                        max_reg[i] <= min_reg[i];
                        min_reg[i] <= max_reg[i];
                    end
                end
                for (int i = 0; i < AXES; i++)
                begin
                    for (int j = HIST_ROWS - 1; j > 0; j--)
                    begin
                        hist_reg[j][i] <= hist_reg[j-1][i];
                    end
                    hist_reg[0][i] <= fv_reg[i];
                end
            end
            if (div_done)
            begin
                noise_reg <= div_quo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (cmd.gate)
            begin
                act_reg[i] <= gate_hit[i];
            end
            if (cmd.diff)
            begin
                d_reg[i]     <= absdiff(fv_reg[i], hist_reg[0][i]);
                cross_reg[i] <= (hist_reg[0][i] > thr_reg[i]) && (thr_reg[i] > fv_reg[i]);
            end
            if (cmd.avg_sum)
            begin
                mag_reg[i] <= mag_val[i];
                neg_reg[i] <= sum_val[i][SUM_W-1];
            end
            if (cmd.avg_mul)
            begin
                prod_reg[i] <= PROD_W'(mag_reg[i]) * PROD_W'(recip);
            end
            if (cmd.upd)
            begin
                sw_reg[i] <= sw_val[i];
            end
        end
        if (cmd.diff)
        begin
            win_reg <= (min_int_reg <= interval_reg) && (interval_reg <= max_int_reg);
        end
        if (cmd.pick)
        begin
            seen_reg <= cross_hit && win_reg;
            axis_reg <= axis_sel;
        end
        if (cmd.load_out)
        begin
            out_total_reg <= step_reg;
            out_seen_reg  <= seen_reg;
            out_axis_reg  <= axis_reg;
        end
    end

    assign step_total  = out_total_reg;
    assign step_seen   = out_seen_reg;
    assign active_axis = out_axis_reg;

endmodule
